// ===== design/nsv_pkg.sv =====
// Shared types, character codes and helpers for the sentence checker.
// Used by nsv_parser, nsv_out_stage and nmea_sentence_validator.
package nsv_pkg;

  // Width of the reported sentence length
  localparam int unsigned FrameLenW = 10;

  // Characters that steer the parse
  localparam logic [7:0] ChDollar = 8'h24;  // '$'
  localparam logic [7:0] ChG      = 8'h47;  // 'G'
  localparam logic [7:0] ChStar   = 8'h2A;  // '*'
  localparam logic [7:0] ChComma  = 8'h2C;  // ','
  localparam logic [7:0] ChNine   = 8'h39;  // '9'

  // Offsets that turn a checksum character into its digit value
  localparam logic [7:0] HexLetterOfs = 8'd55;
  localparam logic [7:0] HexDigitOfs  = 8'h30;

  // One incoming character
  typedef struct packed {
    logic [7:0] byte_value;
    logic       segment_start;
  } in_item_t;

  // One verdict per sentence
  typedef struct packed {
    logic                 frame_ok;
    logic [FrameLenW-1:0] frame_length;
  } out_item_t;

  // Parser step result handed to the output stage
  typedef struct packed {
    logic      emit;
    out_item_t item;
  } step_res_t;

  // Checksum character to value; letters above '9' drop by 55, no range check
  function automatic logic [7:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    if (b > ChNine) v = b - HexLetterOfs;
    else            v = b - HexDigitOfs;
    return v;
  endfunction

endpackage

// ===== design/nmea_sentence_validator.sv =====
// NMEA-style sentence checker: top level with the input register.
// Depends on nsv_pkg, nsv_parser and nsv_out_stage.
//
// Takes one character per item and gives one verdict per sentence: a
// sentence starts on an item with segment_start set and must open with
// "$G"; the XOR of everything from the 'G' up to the '*' is compared with
// the two checksum characters after it, the field after comma number
// DATE_COMMA_INDEX must not be empty if a comma ends it, and the '*' must
// sit at index MAX_SEGMENT-2 or below. frame_length counts '$' through
// the second checksum digit on a pass and is zero on a reject. Bytes
// outside a sentence and sentences cut off by a new start give no
// verdict. The block takes one item every cycle unless in_stall is set;
// each item passes an input register and one parse step into the result
// register, which holds the verdict. Only a stalled result register
// holds up the input.
module nmea_sentence_validator #(
  parameter int unsigned MAX_SEGMENT      = 512,
  parameter int unsigned DATE_COMMA_INDEX = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  nsv_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output nsv_pkg::out_item_t out_item
);
  import nsv_pkg::*;

  in_item_t  in_q;
  logic      in_full;
  logic      adv;
  logic      step_en;
  step_res_t res;

  assign step_en  = in_full && adv;
  assign in_stall = in_full && !adv;

  // Input register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (step_en) begin
      in_full <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_item;
    end
  end

  nsv_parser #(
    .MAX_SEGMENT      (MAX_SEGMENT),
    .DATE_COMMA_INDEX (DATE_COMMA_INDEX)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .item    (in_q),
    .res     (res)
  );

  nsv_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .step_en   (step_en),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .adv       (adv)
  );

  // Input is held off only while a verdict is stuck downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without downstream stall");

  // A held item is still there on the next cycle
  a_in_keep: assert property (@(posedge clk) disable iff (rst)
    in_full && !step_en |=> in_full && $stable(in_q))
    else $error("pending item lost");

  // An empty input register never steps the parser
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !in_full |-> !step_en)
    else $error("parser stepped without an item");

endmodule

// ===== design/nsv_parser.sv =====
// Sentence parse state and the combinational step for one character.
// Depends on nsv_pkg for item types, character codes and hex_value.
module nsv_parser #(
  parameter int unsigned MAX_SEGMENT      = 512,
  parameter int unsigned DATE_COMMA_INDEX = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  nsv_pkg::in_item_t  item,
  output nsv_pkg::step_res_t res
);
  import nsv_pkg::*;

  localparam int unsigned CountW = $clog2(MAX_SEGMENT + 1);
  localparam int unsigned CommaW = $clog2(DATE_COMMA_INDEX + 1);
  localparam logic [CountW-1:0] StarLimit = CountW'(MAX_SEGMENT - 2);
  localparam logic [CommaW-1:0] DateComma = CommaW'(DATE_COMMA_INDEX);

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_WANT_G = 6'b000010,
    PH_BODY   = 6'b000100,
    PH_DATE   = 6'b001000,
    PH_HI     = 6'b010000,
    PH_LO     = 6'b100000
  } phase_t;

  phase_t            phase, phase_next;
  logic [7:0]        xor_sum, xor_sum_next;
  logic [CountW-1:0] byte_count, byte_count_next;
  logic [CommaW-1:0] comma_count, comma_count_next;
  logic [7:0]        high_nibble, high_nibble_next;

  logic [7:0]        b;
  logic [7:0]        digit;
  logic [7:0]        recv_sum;
  logic [CountW:0]   len_full;

  assign b        = item.byte_value;
  assign digit    = hex_value(b);
  assign recv_sum = high_nibble + digit;
  assign len_full = {1'b0, byte_count} + (CountW + 1)'(1);

  // Next state and verdict for the character in the input register
  always_comb begin
    phase_next       = phase;
    xor_sum_next     = xor_sum;
    byte_count_next  = byte_count;
    comma_count_next = comma_count;
    high_nibble_next = high_nibble;
    res              = '0;

    if (item.segment_start) begin
      xor_sum_next     = '0;
      comma_count_next = '0;
      high_nibble_next = '0;
      if (b != ChDollar) begin
        byte_count_next = '0;
        res.emit        = 1'b1;
        phase_next      = PH_IDLE;
      end else begin
        byte_count_next = CountW'(1);
        phase_next      = PH_WANT_G;
      end
    end else begin
      unique case (phase) inside
        PH_IDLE: begin
          // stray bytes between sentences are dropped
        end
        PH_WANT_G: begin
          if (b != ChG) begin
            res.emit   = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            xor_sum_next    = b;
            byte_count_next = CountW'(2);
            phase_next      = PH_BODY;
          end
        end
        PH_BODY, PH_DATE: begin
          if (phase == PH_DATE && b == ChComma) begin
            // empty date field
            res.emit   = 1'b1;
            phase_next = PH_IDLE;
          end else if (b == ChStar) begin
            if (comma_count < DateComma) begin
              res.emit   = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              byte_count_next = byte_count + CountW'(1);
              phase_next      = PH_HI;
            end
          end else if (byte_count >= StarLimit) begin
            // no room left for star and checksum
            res.emit   = 1'b1;
            phase_next = PH_IDLE;
          end else begin
            xor_sum_next    = xor_sum ^ b;
            byte_count_next = byte_count + CountW'(1);
            phase_next      = PH_BODY;
            if (b == ChComma && comma_count < DateComma) begin
              comma_count_next = comma_count + CommaW'(1);
              if (comma_count_next == DateComma) phase_next = PH_DATE;
            end
          end
        end
        PH_HI: begin
          high_nibble_next = {digit[3:0], 4'h0};
          byte_count_next  = byte_count + CountW'(1);
          phase_next       = PH_LO;
        end
        PH_LO: begin
          res.emit          = 1'b1;
          res.item.frame_ok = (recv_sum == xor_sum);
          if (recv_sum == xor_sum) res.item.frame_length = FrameLenW'(len_full);
          phase_next = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      xor_sum     <= '0;
      byte_count  <= '0;
      comma_count <= '0;
      high_nibble <= '0;
    end else if (step_en) begin
      phase       <= phase_next;
      xor_sum     <= xor_sum_next;
      byte_count  <= byte_count_next;
      comma_count <= comma_count_next;
      high_nibble <= high_nibble_next;
    end
  end

  // A verdict always returns the parser to idle
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    step_en && res.emit |=> phase == PH_IDLE)
    else $error("parser not idle after verdict");

  // Checksum digits only follow a star that came after the date comma
  a_hi_commas: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HI || phase == PH_LO |-> comma_count == DateComma)
    else $error("checksum phase with too few commas");

  // Date phase is entered exactly at the date comma
  a_date_commas: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATE |-> comma_count == DateComma)
    else $error("date phase with wrong comma count");

  // Length never runs past the segment size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CountW'(MAX_SEGMENT))
    else $error("byte count past segment size");

endmodule

// ===== design/nsv_out_stage.sv =====
// Result register between the parser and the downstream consumer.
// Depends on nsv_pkg for the verdict types.
module nsv_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                step_en,
  input  nsv_pkg::step_res_t  res,
  input  logic                out_stall,
  output logic                out_valid,
  output nsv_pkg::out_item_t  out_item,
  output logic                adv
);
  import nsv_pkg::*;

  // The parser may step whenever this register is free or being drained
  assign adv = !out_valid || !out_stall;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_en && res.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Verdict payload
  always_ff @(posedge clk) begin
    if (step_en && res.emit) begin
      out_item <= res.item;
    end
  end

  // A new verdict is only loaded when the held one is gone
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !(step_en && res.emit))
    else $error("held verdict overwritten");

  // A rejection always reports zero length
  a_reject_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.frame_ok |-> out_item.frame_length == '0)
    else $error("rejected sentence with nonzero length");

  // A stalled verdict stays in place
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled verdict changed");

endmodule
